// ===== src/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, codes and result type for the bounded integer stack.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int WORD_W  = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int FIDX_W  = 8;
	localparam int COUNT_W = 9;
	localparam int CAP_W   = 9;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam int IN_FIELDS_W  = OP_W + WORD_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STAT_W + WORD_W + FIDX_W + COUNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  data;
		logic        [FIDX_W-1:0]  found_index;
		logic        [COUNT_W-1:0] count;
	} res_t;

endpackage

// ===== src/bis_ram.sv =====
// ----------------------------------------------------------------------------
// bis_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bis_ctrl
// Request sequencer: stack pointer, RAM access and bottom-up search scan.
// ----------------------------------------------------------------------------
module bis_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bis_pkg::OP_W-1:0]     in_op,
	input  logic [bis_pkg::WORD_W-1:0]   in_value,
	input  logic                         out_free,
	input  logic [bis_pkg::CAP_W-1:0]    capacity,
	output logic                         res_valid,
	output bis_pkg::res_t                res
);
	import bis_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    top_q;
	logic [ADDR_W-1:0]   chk_q;
	logic [WORD_W-1:0]   key_q;

	logic                acc;
	op_t                 op;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    limit;
	logic                full;
	logic                empty;
	logic [CNT_W-1:0]    top_p1;
	logic [CNT_W-1:0]    top_m1;
	logic [CNT_W-1:0]    nxt;
	logic                last;
	logic                hit;

	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign op       = op_t'(in_op);

	// capacity beyond the storage depth is capped at the depth
	assign cap_ext = CMP_W'(capacity);
	assign limit   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign full    = CMP_W'(top_q) >= limit;
	assign empty   = (top_q == '0);
	assign top_p1  = top_q + 1'b1;
	assign top_m1  = top_q - 1'b1;

	assign nxt  = CNT_W'(chk_q) + 1'b1;
	assign last = (nxt == top_q);
	assign hit  = (ram_rdata == key_q);

	bis_ram #(
		.DATA_W(WORD_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(top_q[ADDR_W-1:0]),
		.wdata(in_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = top_m1[ADDR_W-1:0];
		res_valid = 1'b0;
		res       = '0;
		res.count = COUNT_W'(top_q);
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (op)
						OP_PUSH: begin
							res_valid = 1'b1;
							if (full) begin
								res.status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								res.count = COUNT_W'(top_p1);
							end
						end
						OP_POP, OP_PEEK: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								ram_re = 1'b1;
							end
						end
						OP_CLEAR: begin
							res_valid = 1'b1;
							res.count = '0;
						end
						OP_SEARCH: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res_valid = 1'b1;
				res.data  = ram_rdata;
			end
			S_SCAN: begin
				if (hit) begin
					res_valid       = 1'b1;
					res.found_index = FIDX_W'(chk_q);
				end else if (last) begin
					res_valid  = 1'b1;
					res.status = ST_NOTFOUND;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = nxt[ADDR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (op)
							OP_PUSH: begin
								if (!full) top_q <= top_p1;
							end
							OP_POP: begin
								if (!empty) begin
									top_q   <= top_m1;
									state_q <= S_READ;
								end
							end
							OP_PEEK: begin
								if (!empty) state_q <= S_READ;
							end
							OP_CLEAR: begin
								top_q <= '0;
							end
							OP_SEARCH: begin
								if (!empty) state_q <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (hit || last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan position and search key
	always_ff @(posedge clk) begin
		if (acc && op == OP_SEARCH) begin
			chk_q <= '0;
			key_q <= in_value;
		end else if (state_q == S_SCAN && !hit && !last) begin
			chk_q <= nxt[ADDR_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(top_q) <= CMP_W'(DEPTH))
		else $error("stack pointer beyond depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CNT_W'(chk_q) < top_q)
		else $error("scan position outside held entries");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == OP_PUSH && !full |=> top_q == $past(top_p1))
		else $error("accepted push did not grow the stack");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("request taken while a read or scan is in flight");
`endif

endmodule

// ===== src/bounded_integer_stack_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_stack_unit
// Push, clear, failed and unknown requests: result registered the cycle
// after the transaction, one request per cycle while the output is free.
// Pop and peek: registered RAM read, then output register. Search: scans up
// from the bottom to the first match or the top, one RAM read per cycle.
// Reset clears the count and sets capacity to 256, not the stored words.
// ----------------------------------------------------------------------------
module bounded_integer_stack_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: operation [2:0], value [34:3], zero pad above
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bis_pkg::IN_TDATA_W-1:0]    s_tdata,
	// m_tdata: status [1:0], data [33:2], found_index [41:34], count [50:42]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bis_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// capacity write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bis_pkg::CAP_W-1:0]         cfg_data
);
	import bis_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             m_tvalid_q;
	res_t             out_q;
	logic             out_free;
	logic             res_valid;
	res_t             res;

	// config writes land at any time; host only writes when idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// output register frees up the cycle its transaction completes
	assign out_free = !m_tvalid_q || m_tready;

	bis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tdata[OP_W-1:0]),
		.in_value (s_tdata[OP_W +: WORD_W]),
		.out_free (out_free),
		.capacity (capacity_q),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_q.count, out_q.found_index,
		out_q.data, out_q.status};

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending output transaction");
`endif

endmodule

// ===== bench/bis_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bis_result_checker
// Watches the request, result and capacity channels of the stack unit, keeps
// its own copy of the stack, predicts every result and compares the fields.
// ----------------------------------------------------------------------------
module bis_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bis_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bis_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bis_pkg::CAP_W-1:0]       cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import bis_pkg::*;

	localparam int DATA_LSB  = STAT_W;
	localparam int FIDX_LSB  = STAT_W + WORD_W;
	localparam int COUNT_LSB = STAT_W + WORD_W + FIDX_W;

	logic [WORD_W-1:0] stack_words [DEPTH];
	logic [CNT_W-1:0]  stack_count;
	logic [CAP_W-1:0]  cap_reg;
	res_t              expected_results [$];
	int                errors = 0;
	int                results_seen = 0;

	assign mismatches = errors;

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: result %0d, %s mismatch: expected %0h, got %0h",
			$time, results_seen, what, want, got);
		errors++;
	endtask

	// Applies one request to the shadow stack and returns its result.
	function automatic res_t apply_request(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] val);
		res_t r;
		int   lim;
		bit   hit;
		r.status      = ST_OK;
		r.data        = '0;
		r.found_index = '0;
		lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		case (op)
			OP_PUSH: begin
				if (int'(stack_count) >= lim) begin
					r.status = ST_FULL;
				end else begin
					stack_words[stack_count[ADDR_W-1:0]] = val;
					stack_count = stack_count + 1'b1;
				end
			end
			OP_POP: begin
				if (stack_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_count = stack_count - 1'b1;
					r.data = stack_words[stack_count[ADDR_W-1:0]];
				end
			end
			OP_PEEK: begin
				if (stack_count == 0)
					r.status = ST_EMPTY;
				else
					r.data = stack_words[ADDR_W'(stack_count - 1'b1)];
			end
			OP_CLEAR: begin
				stack_count = '0;
			end
			OP_SEARCH: begin
				if (stack_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_NOTFOUND;
					hit = 1'b0;
					// first match counted from the bottom
					for (int i = 0; i < int'(stack_count); i++) begin
						if (!hit && stack_words[ADDR_W'(i)] == val) begin
							hit = 1'b1;
							r.status = ST_OK;
							r.found_index = FIDX_W'(i);
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(stack_count);
		return r;
	endfunction

	task automatic check_result(input logic [OUT_TDATA_W-1:0] beat);
		res_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			note_mismatch("unexpected result", '0, 64'(beat));
		end else begin
			want = expected_results.pop_front();
			if (beat[STAT_W-1:0] !== want.status)
				note_mismatch("status", 64'(want.status), 64'(beat[STAT_W-1:0]));
			if (beat[DATA_LSB +: WORD_W] !== want.data)
				note_mismatch("data", 64'(want.data), 64'(beat[DATA_LSB +: WORD_W]));
			if (beat[FIDX_LSB +: FIDX_W] !== want.found_index)
				note_mismatch("found_index", 64'(want.found_index),
					64'(beat[FIDX_LSB +: FIDX_W]));
			if (beat[COUNT_LSB +: COUNT_W] !== want.count)
				note_mismatch("count", 64'(want.count),
					64'(beat[COUNT_LSB +: COUNT_W]));
		end
	endtask

	// results are taken before requests so a stray beat never matches an
	// expectation pushed at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count = '0;
			cap_reg     = CAP_RESET;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(s_tdata[OP_W-1:0],
					s_tdata[OP_W +: WORD_W]));
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== bench/tb_bounded_integer_stack_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_integer_stack_unit
// Drives requests and capacity writes into the stack unit with random stalls
// on both sides; a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module tb_bounded_integer_stack_unit;
	import bis_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 5;
	// worst quiet stretch: long receiver hold plus a full-depth search
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	// a search over a full stack reads all DEPTH entries
	localparam int DRAIN_CYCLES   = DEPTH + 8;

	// codes the unit ignores
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CAP_W-1:0]       cfg_data  = '0;

	int mismatches;
	int outstanding;

	// stimulus controls
	logic calm        = 1'b0;   // no idling on either side
	logic hold_req    = 1'b0;   // ask the receiver for one long hold
	logic hold_served = 1'b0;
	int   idle_cycles = 0;

	logic [WORD_W-1:0] pushed_words [$];   // recent pushes, used as search keys

	always #(CLK_PERIOD / 2) clk = ~clk;

	bounded_integer_stack_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bis_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: ends the run if no transaction of any kind goes through for
	// too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold on request, none once calm.
	// The hold is counted here so the sender keeps offering meanwhile.
	initial begin : receiver
		int hold_left;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				m_tready <= 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(negedge clk);
					hold_left--;
				end
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				// the loop's own falling edge also lies within the stall
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One request transaction. Entered and left at a falling edge; s_tvalid
	// stays high into the next request unless an idle burst comes first.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({val, op});
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Drop the request valid and wait until every result is back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Capacity is only changed with the unit idle.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A run of random requests with weighted operations. Narrow mode draws
	// values from a tiny pool so duplicates and search hits are frequent.
	task automatic run_phase(input int items, input int w_push, input int w_pop,
			input int w_peek, input int w_search, input int w_clear,
			input int w_spare, input bit narrow);
		int                total;
		int                pick;
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] val;
		total = w_push + w_pop + w_peek + w_search + w_clear + w_spare;
		repeat (items) begin
			pick = $urandom_range(1, total);
			if (pick <= w_push)
				op = OP_PUSH;
			else if (pick <= w_push + w_pop)
				op = OP_POP;
			else if (pick <= w_push + w_pop + w_peek)
				op = OP_PEEK;
			else if (pick <= w_push + w_pop + w_peek + w_search)
				op = OP_SEARCH;
			else if (pick <= total - w_spare)
				op = OP_CLEAR;
			else begin
				case ($urandom_range(0, 2))
					0:       op = OP_SPARE_5;
					1:       op = OP_SPARE_6;
					default: op = OP_SPARE_7;
				endcase
			end

			if (narrow) begin
				val = WORD_W'($urandom_range(0, 7)) - WORD_W'(4);
			end else begin
				case ($urandom_range(0, 15))
					0:       val = WORD_MIN;
					1:       val = WORD_MAX;
					2:       val = '0;
					3:       val = WORD_ONES;
					default: val = $urandom;
				endcase
				// half the wide searches look for a word pushed lately
				if (op == OP_SEARCH && pushed_words.size() > 0 &&
						$urandom_range(0, 1) == 1)
					val = pushed_words[$urandom_range(0, pushed_words.size() - 1)];
			end

			if (op == OP_PUSH) begin
				pushed_words.push_back(val);
				if (pushed_words.size() > 64)
					void'(pushed_words.pop_front());
			end
			send_request(op, val);
		end
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty stack, word extremes, hit / miss, ignored codes.
		send_request(OP_POP, '0);
		send_request(OP_PEEK, '0);
		send_request(OP_SEARCH, '0);
		send_request(OP_PUSH, WORD_MIN);
		send_request(OP_PUSH, WORD_MAX);
		send_request(OP_PUSH, '0);
		send_request(OP_PUSH, WORD_ONES);
		send_request(OP_PEEK, '0);
		send_request(OP_SEARCH, WORD_MAX);
		send_request(OP_SEARCH, WORD_MIN);
		send_request(OP_SEARCH, 32'd12345);
		send_request(OP_SPARE_5, WORD_ONES);
		send_request(OP_SPARE_6, '0);
		send_request(OP_SPARE_7, WORD_MAX);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_CLEAR, WORD_ONES);
		send_request(OP_POP, '0);

		// zero capacity: every push is full
		write_capacity('0);
		send_request(OP_PUSH, 32'h0BAD_F00D);
		send_request(OP_PEEK, '0);

		// capacity of one
		write_capacity(CAP_W'(1));
		send_request(OP_PUSH, 32'h1234_5678);
		send_request(OP_PUSH, 32'hDEAD_BEEF);
		send_request(OP_SEARCH, 32'h1234_5678);
		send_request(OP_POP, '0);

		// Random part.
		// capacity above the stack depth: fill up until pushes report full
		write_capacity('1);
		run_phase(360, 85, 3, 4, 6, 0, 2, 1'b0);

		// capacity far below the held count: entries kept, pushes full
		write_capacity(CAP_W'(20));
		run_phase(150, 30, 45, 10, 12, 1, 2, 1'b0);

		// receiver holds off for a long stretch while requests keep coming
		write_capacity(CAP_RESET);
		hold_req <= 1'b1;
		run_phase(200, 40, 25, 10, 15, 2, 8, 1'b1);

		write_capacity(CAP_W'(255));
		run_phase(280, 50, 30, 10, 8, 1, 1, 1'b0);

		write_capacity('0);
		run_phase(60, 40, 30, 10, 15, 0, 5, 1'b1);

		write_capacity(CAP_W'(8));
		run_phase(240, 45, 35, 5, 10, 3, 2, 1'b1);

		write_capacity(CAP_W'($urandom_range(0, 511)));
		run_phase(240, 45, 30, 8, 12, 2, 3, 1'b0);

		// last stretch with no idling on either side
		write_capacity(CAP_RESET);
		calm <= 1'b1;
		run_phase(300, 45, 30, 8, 12, 2, 3, 1'b1);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bis_pkg.sv
src/bis_ram.sv
src/bis_ctrl.sv
src/bounded_integer_stack_unit.sv
bench/bis_result_checker.sv
bench/tb_bounded_integer_stack_unit.sv
